>>> sv/rrtm_pkg.sv
package rrtm_pkg;

  localparam int TASKS_DEF    = 16;
  localparam int SIGNALS_DEF  = 32;
  localparam int PID_BITS_DEF = 16;

  localparam int ACTION_W = 4;
  localparam int TPID_W   = 16;
  localparam int SIG_W    = 5;
  localparam int CODE_W   = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CREATE_KERNEL = 4'd0,
    ACT_CREATE_USER   = 4'd1,
    ACT_WAKE          = 4'd2,
    ACT_YIELD         = 4'd3,
    ACT_EXIT          = 4'd4,
    ACT_STOP          = 4'd5,
    ACT_SIGNAL        = 4'd6,
    ACT_WAITPID       = 4'd7,
    ACT_REAP          = 4'd8
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_ERROR   = 2'd1,
    STAT_BLOCKED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TS_RUNNING  = 2'd0,
    TS_RUNNABLE = 2'd1,
    TS_WAITING  = 2'd2,
    TS_ZOMBIE   = 2'd3
  } tstate_e;

  // Commands from the controller to the datapath.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERROR,
    OP_CREATE,
    OP_T_FIND,
    OP_T_CHILD,
    OP_T_CUR,
    OP_WAKE_T,
    OP_PICK,
    OP_EXIT_CUR,
    OP_STOP_T,
    OP_WAKE_PARENT,
    OP_SET_HANDLER,
    OP_PEND,
    OP_REAP_CHILD,
    OP_WAIT_CUR,
    OP_MARK,
    OP_FREE_SWEEP
  } op_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e act;
    logic    hp;
    logic    free_hit;
    logic    pid_full;
    logic    find_hit;
    logic    child_hit;
    logic    sig_bad;
    logic    t_zero;
    logic    t_cur;
    logic    t_user;
    tstate_e t_state;
    logic    t_handler;
    logic    sweep_last;
  } stat_t;

endpackage

>>> sv/rrtm_ctrl.sv
module rrtm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output logic           done_o,
  input  rrtm_pkg::stat_t stat_i,
  output rrtm_pkg::op_e  op_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_DECODE = 10'b00_0000_0010,
    S_CHECK  = 10'b00_0000_0100,
    S_EXIT1  = 10'b00_0000_1000,
    S_EXIT2  = 10'b00_0001_0000,
    S_EXIT3  = 10'b00_0010_0000,
    S_WPAR   = 10'b00_0100_0000,
    S_WCHK   = 10'b00_1000_0000,
    S_SWEEP  = 10'b01_0000_0000,
    S_FINISH = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_FINISH);

  always_comb begin
    state_d = state_q;
    op_o    = rrtm_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_o    = rrtm_pkg::OP_LOAD;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.act)
          rrtm_pkg::ACT_CREATE_KERNEL, rrtm_pkg::ACT_CREATE_USER: begin
            op_o    = (!stat_i.free_hit || stat_i.pid_full) ? rrtm_pkg::OP_ERROR
                                                            : rrtm_pkg::OP_CREATE;
            state_d = S_FINISH;
          end
          rrtm_pkg::ACT_WAKE, rrtm_pkg::ACT_STOP: begin
            if (stat_i.find_hit) begin
              op_o    = rrtm_pkg::OP_T_FIND;
              state_d = S_CHECK;
            end else begin
              op_o    = rrtm_pkg::OP_ERROR;
              state_d = S_FINISH;
            end
          end
          rrtm_pkg::ACT_SIGNAL: begin
            if (stat_i.find_hit && !stat_i.sig_bad) begin
              op_o    = rrtm_pkg::OP_T_FIND;
              state_d = S_CHECK;
            end else begin
              op_o    = rrtm_pkg::OP_ERROR;
              state_d = S_FINISH;
            end
          end
          rrtm_pkg::ACT_YIELD: begin
            op_o    = rrtm_pkg::OP_PICK;
            state_d = S_FINISH;
          end
          rrtm_pkg::ACT_EXIT: begin
            op_o    = rrtm_pkg::OP_T_CUR;
            state_d = S_EXIT1;
          end
          rrtm_pkg::ACT_WAITPID: begin
            if (stat_i.child_hit) begin
              op_o    = rrtm_pkg::OP_T_CHILD;
              state_d = S_WCHK;
            end else begin
              op_o    = rrtm_pkg::OP_ERROR;
              state_d = S_FINISH;
            end
          end
          rrtm_pkg::ACT_REAP: begin
            op_o    = rrtm_pkg::OP_MARK;
            state_d = S_SWEEP;
          end
          default: begin
            op_o    = rrtm_pkg::OP_ERROR;
            state_d = S_FINISH;
          end
        endcase
      end
      S_CHECK: begin
        state_d = S_FINISH;
        case (stat_i.act)
          rrtm_pkg::ACT_WAKE: begin
            op_o = (stat_i.t_state == rrtm_pkg::TS_WAITING) ? rrtm_pkg::OP_WAKE_T
                                                           : rrtm_pkg::OP_ERROR;
          end
          rrtm_pkg::ACT_STOP: begin
            if (stat_i.t_zero) begin
              op_o = rrtm_pkg::OP_ERROR;
            end else if (stat_i.t_cur) begin
              state_d = S_EXIT1;
            end else if (!stat_i.t_user || stat_i.t_state == rrtm_pkg::TS_ZOMBIE) begin
              op_o = rrtm_pkg::OP_ERROR;
            end else begin
              op_o    = rrtm_pkg::OP_STOP_T;
              state_d = S_WPAR;
            end
          end
          rrtm_pkg::ACT_SIGNAL: begin
            if (stat_i.hp) begin
              op_o = rrtm_pkg::OP_SET_HANDLER;
            end else if (stat_i.t_zero || !stat_i.t_user ||
                         stat_i.t_state == rrtm_pkg::TS_ZOMBIE) begin
              op_o = rrtm_pkg::OP_ERROR;
            end else if (stat_i.t_handler) begin
              op_o = rrtm_pkg::OP_PEND;
            end else if (stat_i.t_cur) begin
              state_d = S_EXIT1;
            end else begin
              op_o    = rrtm_pkg::OP_STOP_T;
              state_d = S_WPAR;
            end
          end
          default: begin
            op_o = rrtm_pkg::OP_ERROR;
          end
        endcase
      end
      S_EXIT1: begin
        op_o    = rrtm_pkg::OP_EXIT_CUR;
        state_d = S_EXIT2;
      end
      S_EXIT2: begin
        op_o    = rrtm_pkg::OP_WAKE_PARENT;
        state_d = S_EXIT3;
      end
      S_EXIT3: begin
        op_o    = rrtm_pkg::OP_PICK;
        state_d = S_FINISH;
      end
      S_WPAR: begin
        op_o    = rrtm_pkg::OP_WAKE_PARENT;
        state_d = S_FINISH;
      end
      S_WCHK: begin
        if (stat_i.t_state == rrtm_pkg::TS_ZOMBIE) begin
          op_o    = rrtm_pkg::OP_REAP_CHILD;
          state_d = S_FINISH;
        end else begin
          op_o    = rrtm_pkg::OP_WAIT_CUR;
          state_d = S_EXIT3;
        end
      end
      S_SWEEP: begin
        op_o = rrtm_pkg::OP_FREE_SWEEP;
        if (stat_i.sweep_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/rrtm_dp.sv
module rrtm_dp #(
  parameter int TASKS    = rrtm_pkg::TASKS_DEF,
  parameter int SIGNALS  = rrtm_pkg::SIGNALS_DEF,
  parameter int PID_BITS = rrtm_pkg::PID_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rrtm_pkg::op_e                      op_i,
  input  logic [rrtm_pkg::ACTION_W-1:0]      action_i,
  input  logic [rrtm_pkg::TPID_W-1:0]        target_pid_i,
  input  logic [rrtm_pkg::SIG_W-1:0]         signal_number_i,
  input  logic signed [rrtm_pkg::CODE_W-1:0] exit_code_i,
  input  logic                               handler_present_i,
  output rrtm_pkg::stat_t                    stat_o,
  output logic [rrtm_pkg::STATUS_W-1:0]      status_o,
  output logic [rrtm_pkg::TPID_W-1:0]        result_pid_o,
  output logic [rrtm_pkg::TPID_W-1:0]        running_pid_o,
  output logic                               switched_o
);

  localparam int SW   = $clog2(TASKS);
  localparam int PW   = $clog2(TASKS + 1);
  localparam int CMPW = (PID_BITS > rrtm_pkg::TPID_W) ? PID_BITS : rrtm_pkg::TPID_W;
  localparam logic [PW-1:0] NO_PARENT = PW'(TASKS);

  // Task table.
  logic                             valid_q [TASKS], valid_d [TASKS];
  logic [PID_BITS-1:0]              pid_q   [TASKS], pid_d   [TASKS];
  rrtm_pkg::tstate_e                st_q    [TASKS], st_d    [TASKS];
  logic                             user_q  [TASKS], user_d  [TASKS];
  logic [PW-1:0]                    par_q   [TASKS], par_d   [TASKS];
  logic                             wnone_q [TASKS], wnone_d [TASKS];
  logic [PID_BITS-1:0]              wait_q  [TASKS], wait_d  [TASKS];
  logic [rrtm_pkg::CODE_W-1:0]      xc_q    [TASKS], xc_d    [TASKS];
  logic [SIGNALS-1:0]               pend_q  [TASKS], pend_d  [TASKS];
  logic [SIGNALS-1:0]               hnd_q   [TASKS], hnd_d   [TASKS];

  // Run queue.
  logic [SW-1:0]                    ord_q [TASKS], ord_d [TASKS];
  logic [PW-1:0]                    cnt_q, cnt_d;

  logic [PID_BITS:0]                npid_q, npid_d;
  logic [SW-1:0]                    cur_q, cur_d;

  // Per-command working registers.
  rrtm_pkg::action_e                act_q, act_d;
  logic [rrtm_pkg::TPID_W-1:0]      tpid_q, tpid_d;
  logic [rrtm_pkg::SIG_W-1:0]       sig_q, sig_d;
  logic [rrtm_pkg::CODE_W-1:0]      code_q, code_d;
  logic                             hp_q, hp_d;
  logic [SW-1:0]                    before_q, before_d;
  logic [SW-1:0]                    t_q, t_d;
  rrtm_pkg::status_e                status_q, status_d;
  logic [rrtm_pkg::TPID_W-1:0]      rpid_q, rpid_d;
  logic [TASKS-1:0]                 marks_q, marks_d;
  logic [SW-1:0]                    sw_q, sw_d;

  // Queue requests.
  logic                             q_rem, q_pop, q_push;
  logic [SW-1:0]                    q_rem_slot, q_push_slot;

  logic                             orph_en, clr_en;
  logic [SW-1:0]                    orph_slot, clr_slot;

  logic                             find_hit, free_hit;
  logic [SW-1:0]                    find_idx, free_idx;
  logic [SIGNALS-1:0]               sig_mask;
  logic [PW-1:0]                    par_t;
  logic [SW-1:0]                    par_slot;

  assign sig_mask = SIGNALS'(1) << sig_q;
  assign par_t    = par_q[t_q];
  assign par_slot = par_t[SW-1:0];

  always_comb begin
    find_hit  = 1'b0;
    free_hit  = 1'b0;
    find_idx  = '0;
    free_idx  = '0;
    for (int i = TASKS - 1; i >= 0; i--) begin
      if (valid_q[i] && CMPW'(pid_q[i]) == CMPW'(tpid_q)) begin
        find_hit = 1'b1;
        find_idx = SW'(i);
      end
      if (!valid_q[i]) begin
        free_hit = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // The child search must give the lowest matching child, not the lowest pid match.
  logic             child_hit2;
  logic [SW-1:0]    child_idx2;
  always_comb begin
    child_hit2 = 1'b0;
    child_idx2 = '0;
    for (int i = TASKS - 1; i >= 0; i--) begin
      if (valid_q[i] && par_q[i] == PW'(cur_q) && CMPW'(pid_q[i]) == CMPW'(tpid_q)) begin
        child_hit2 = 1'b1;
        child_idx2 = SW'(i);
      end
    end
  end

  always_comb begin
    stat_o.act        = act_q;
    stat_o.hp         = hp_q;
    stat_o.free_hit   = free_hit;
    stat_o.pid_full   = npid_q[PID_BITS];
    stat_o.find_hit   = find_hit;
    stat_o.child_hit  = child_hit2;
    stat_o.sig_bad    = (sig_q == '0) || (32'(sig_q) >= 32'(SIGNALS));
    stat_o.t_zero     = (t_q == '0);
    stat_o.t_cur      = (t_q == cur_q);
    stat_o.t_user     = user_q[t_q];
    stat_o.t_state    = st_q[t_q];
    stat_o.t_handler  = |(hnd_q[t_q] & sig_mask);
    stat_o.sweep_last = (sw_q == SW'(TASKS - 1));
  end

  // Table and control update.
  always_comb begin
    valid_d = valid_q; pid_d = pid_q; st_d = st_q; user_d = user_q; par_d = par_q;
    wnone_d = wnone_q; wait_d = wait_q; xc_d = xc_q; pend_d = pend_q; hnd_d = hnd_q;
    npid_d = npid_q; cur_d = cur_q;
    act_d = act_q; tpid_d = tpid_q; sig_d = sig_q; code_d = code_q; hp_d = hp_q;
    before_d = before_q; t_d = t_q; status_d = status_q; rpid_d = rpid_q;
    marks_d = marks_q; sw_d = sw_q;
    q_rem = 1'b0; q_pop = 1'b0; q_push = 1'b0;
    q_rem_slot = '0; q_push_slot = '0;
    orph_en = 1'b0; orph_slot = '0; clr_en = 1'b0; clr_slot = '0;

    case (op_i)
      rrtm_pkg::OP_LOAD: begin
        act_d    = rrtm_pkg::action_e'(action_i);
        tpid_d   = target_pid_i;
        sig_d    = signal_number_i;
        code_d   = exit_code_i;
        hp_d     = handler_present_i;
        before_d = cur_q;
        status_d = rrtm_pkg::STAT_OK;
        rpid_d   = target_pid_i;
      end
      rrtm_pkg::OP_ERROR: begin
        status_d = rrtm_pkg::STAT_ERROR;
      end
      rrtm_pkg::OP_CREATE: begin
        valid_d[free_idx] = 1'b1;
        pid_d[free_idx]   = npid_q[PID_BITS-1:0];
        wnone_d[free_idx] = 1'b1;
        wait_d[free_idx]  = '0;
        xc_d[free_idx]    = '0;
        pend_d[free_idx]  = '0;
        hnd_d[free_idx]   = '0;
        rpid_d            = rrtm_pkg::TPID_W'(npid_q);
        npid_d            = npid_q + 1'b1;
        if (act_q == rrtm_pkg::ACT_CREATE_KERNEL) begin
          user_d[free_idx] = 1'b0;
          par_d[free_idx]  = NO_PARENT;
          st_d[free_idx]   = rrtm_pkg::TS_RUNNABLE;
          q_push           = 1'b1;
          q_push_slot      = free_idx;
        end else begin
          user_d[free_idx] = 1'b1;
          par_d[free_idx]  = PW'(cur_q);
          st_d[free_idx]   = rrtm_pkg::TS_WAITING;
        end
      end
      rrtm_pkg::OP_T_FIND:  t_d = find_idx;
      rrtm_pkg::OP_T_CHILD: t_d = child_idx2;
      rrtm_pkg::OP_T_CUR:   t_d = cur_q;
      rrtm_pkg::OP_WAKE_T: begin
        st_d[t_q]   = rrtm_pkg::TS_RUNNABLE;
        q_rem       = 1'b1;
        q_rem_slot  = t_q;
        q_push      = 1'b1;
        q_push_slot = t_q;
      end
      rrtm_pkg::OP_PICK: begin
        if (cnt_q != '0) begin
          q_pop = 1'b1;
          if (ord_q[0] == cur_q) begin
            st_d[cur_q] = rrtm_pkg::TS_RUNNING;
          end else begin
            if (st_q[cur_q] == rrtm_pkg::TS_RUNNING && cur_q != '0) begin
              st_d[cur_q] = rrtm_pkg::TS_RUNNABLE;
              q_push      = 1'b1;
              q_push_slot = cur_q;
            end
            st_d[ord_q[0]] = rrtm_pkg::TS_RUNNING;
            cur_d          = ord_q[0];
          end
        end
      end
      rrtm_pkg::OP_EXIT_CUR: begin
        xc_d[t_q] = (act_q == rrtm_pkg::ACT_EXIT) ? code_q : '0;
        st_d[t_q] = rrtm_pkg::TS_ZOMBIE;
        orph_en   = 1'b1;
        orph_slot = t_q;
      end
      rrtm_pkg::OP_STOP_T: begin
        if (st_q[t_q] == rrtm_pkg::TS_RUNNABLE) begin
          q_rem      = 1'b1;
          q_rem_slot = t_q;
        end
        xc_d[t_q]    = '0;
        wnone_d[t_q] = 1'b1;
        st_d[t_q]    = rrtm_pkg::TS_ZOMBIE;
        orph_en      = 1'b1;
        orph_slot    = t_q;
      end
      rrtm_pkg::OP_WAKE_PARENT: begin
        if (par_t < PW'(TASKS)) begin
          if (valid_q[par_slot] && st_q[par_slot] == rrtm_pkg::TS_WAITING &&
              !wnone_q[par_slot] && wait_q[par_slot] == pid_q[t_q]) begin
            wnone_d[par_slot] = 1'b1;
            st_d[par_slot]    = rrtm_pkg::TS_RUNNABLE;
            q_rem             = 1'b1;
            q_rem_slot        = par_slot;
            q_push            = 1'b1;
            q_push_slot       = par_slot;
          end
        end
      end
      rrtm_pkg::OP_SET_HANDLER: begin
        hnd_d[t_q] = hnd_q[t_q] | sig_mask;
      end
      rrtm_pkg::OP_PEND: begin
        pend_d[t_q] = pend_q[t_q] | sig_mask;
        if (st_q[t_q] == rrtm_pkg::TS_WAITING) begin
          st_d[t_q]   = rrtm_pkg::TS_RUNNABLE;
          q_rem       = 1'b1;
          q_rem_slot  = t_q;
          q_push      = 1'b1;
          q_push_slot = t_q;
        end
      end
      rrtm_pkg::OP_REAP_CHILD: begin
        rpid_d     = rrtm_pkg::TPID_W'(pid_q[t_q]);
        orph_en    = 1'b1;
        orph_slot  = t_q;
        q_rem      = 1'b1;
        q_rem_slot = t_q;
        clr_en     = 1'b1;
        clr_slot   = t_q;
      end
      rrtm_pkg::OP_WAIT_CUR: begin
        wait_d[cur_q]  = PID_BITS'(tpid_q);
        wnone_d[cur_q] = 1'b0;
        st_d[cur_q]    = rrtm_pkg::TS_WAITING;
        status_d       = rrtm_pkg::STAT_BLOCKED;
      end
      rrtm_pkg::OP_MARK: begin
        for (int i = 0; i < TASKS; i++) begin
          marks_d[i] = valid_q[i] && st_q[i] == rrtm_pkg::TS_ZOMBIE &&
                       par_q[i] == NO_PARENT && i != 0 && SW'(i) != cur_q;
        end
        sw_d = '0;
      end
      rrtm_pkg::OP_FREE_SWEEP: begin
        if (marks_q[sw_q]) begin
          orph_en    = 1'b1;
          orph_slot  = sw_q;
          q_rem      = 1'b1;
          q_rem_slot = sw_q;
          clr_en     = 1'b1;
          clr_slot   = sw_q;
        end
        sw_d = sw_q + 1'b1;
      end
      default: begin
      end
    endcase

    if (orph_en) begin
      for (int i = 0; i < TASKS; i++) begin
        if (valid_q[i] && par_q[i] == PW'(orph_slot)) begin
          par_d[i] = NO_PARENT;
        end
      end
    end
    if (clr_en) begin
      valid_d[clr_slot] = 1'b0;
      pid_d[clr_slot]   = '0;
      st_d[clr_slot]    = rrtm_pkg::TS_RUNNING;
      user_d[clr_slot]  = 1'b0;
      par_d[clr_slot]   = NO_PARENT;
      wnone_d[clr_slot] = 1'b1;
      wait_d[clr_slot]  = '0;
      xc_d[clr_slot]    = '0;
      pend_d[clr_slot]  = '0;
      hnd_d[clr_slot]   = '0;
    end
  end

  // Queue: one removal (or pop of the head) and then one push per cycle.
  always_comb begin
    logic          rm_hit;
    logic [SW-1:0] rm_pos;
    logic [PW-1:0] cnt1;
    rm_hit = 1'b0;
    rm_pos = '0;
    ord_d  = ord_q;
    if (q_pop) begin
      rm_hit = (cnt_q != '0);
    end else if (q_rem) begin
      for (int r = TASKS - 1; r >= 0; r--) begin
        if (PW'(r) < cnt_q && ord_q[r] == q_rem_slot) begin
          rm_hit = 1'b1;
          rm_pos = SW'(r);
        end
      end
    end
    cnt1 = cnt_q;
    if (rm_hit) begin
      for (int r = 0; r < TASKS - 1; r++) begin
        if (SW'(r) >= rm_pos) begin
          ord_d[r] = ord_q[r + 1];
        end
      end
      cnt1 = cnt_q - 1'b1;
    end
    if (q_push && cnt1 < PW'(TASKS)) begin
      for (int r = 0; r < TASKS; r++) begin
        if (PW'(r) == cnt1) begin
          ord_d[r] = q_push_slot;
        end
      end
      cnt1 = cnt1 + 1'b1;
    end
    cnt_d = cnt1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASKS; i++) begin
        valid_q[i] <= (i == 0);
        pid_q[i]   <= '0;
        st_q[i]    <= rrtm_pkg::TS_RUNNING;
        user_q[i]  <= 1'b0;
        par_q[i]   <= NO_PARENT;
        wnone_q[i] <= 1'b1;
        wait_q[i]  <= '0;
        xc_q[i]    <= '0;
        pend_q[i]  <= '0;
        hnd_q[i]   <= '0;
      end
      cnt_q  <= '0;
      npid_q <= (PID_BITS + 1)'(1);
      cur_q  <= '0;
    end else begin
      valid_q <= valid_d;
      pid_q   <= pid_d;
      st_q    <= st_d;
      user_q  <= user_d;
      par_q   <= par_d;
      wnone_q <= wnone_d;
      wait_q  <= wait_d;
      xc_q    <= xc_d;
      pend_q  <= pend_d;
      hnd_q   <= hnd_d;
      cnt_q   <= cnt_d;
      npid_q  <= npid_d;
      cur_q   <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ord_q    <= ord_d;
    act_q    <= act_d;
    tpid_q   <= tpid_d;
    sig_q    <= sig_d;
    code_q   <= code_d;
    hp_q     <= hp_d;
    before_q <= before_d;
    t_q      <= t_d;
    status_q <= status_d;
    rpid_q   <= rpid_d;
    marks_q  <= marks_d;
    sw_q     <= sw_d;
  end

  assign status_o      = status_q;
  assign result_pid_o  = rpid_q;
  assign running_pid_o = rrtm_pkg::TPID_W'(pid_q[cur_q]);
  assign switched_o    = (cur_q != before_q);

endmodule

>>> sv/round_robin_task_manager_unit.sv
// Create, yield and errors found at decode finish from decode; wake, signal and
// set-handler pass a check step; waitpid checks the child, then reaps it or waits and
// picks; stop checks, stops and wakes the parent, or exits if it stops the running
// task; exit runs exit, parent wake and pick; reap marks, then a sweep counter visits
// every slot. One transaction at a time; busy drops the cycle after the result strobe.
// Reset (rst_ni low, asynchronous) leaves only the boot task in slot 0, running,
// with an empty run queue and the next pid at one. The receiver cannot stall.
module round_robin_task_manager_unit #(
  parameter int TASKS    = rrtm_pkg::TASKS_DEF,
  parameter int SIGNALS  = rrtm_pkg::SIGNALS_DEF,
  parameter int PID_BITS = rrtm_pkg::PID_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [rrtm_pkg::ACTION_W-1:0]      action_i,
  input  logic [rrtm_pkg::TPID_W-1:0]        target_pid_i,
  input  logic [rrtm_pkg::SIG_W-1:0]         signal_number_i,
  input  logic signed [rrtm_pkg::CODE_W-1:0] exit_code_i,
  input  logic                               handler_present_i,
  output logic                               done_o,
  output logic [rrtm_pkg::STATUS_W-1:0]      status_o,
  output logic [rrtm_pkg::TPID_W-1:0]        result_pid_o,
  output logic [rrtm_pkg::TPID_W-1:0]        running_pid_o,
  output logic                               switched_o
);

  // The controller walks each command through a short sequence of datapath
  // operations; the datapath holds the task table, the run queue and the
  // registers of the transaction in progress.
  rrtm_pkg::op_e   op;
  rrtm_pkg::stat_t stat;

  rrtm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .op_o   (op)
  );

  rrtm_dp #(
    .TASKS    (TASKS),
    .SIGNALS  (SIGNALS),
    .PID_BITS (PID_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op),
    .action_i          (action_i),
    .target_pid_i      (target_pid_i),
    .signal_number_i   (signal_number_i),
    .exit_code_i       (exit_code_i),
    .handler_present_i (handler_present_i),
    .stat_o            (stat),
    .status_o          (status_o),
    .result_pid_o      (result_pid_o),
    .running_pid_o     (running_pid_o),
    .switched_o        (switched_o)
  );

`ifndef SYNTHESIS
  // A transaction is only loaded when the handshake accepts it.
  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == rrtm_pkg::OP_LOAD) |-> (start && !busy))
    else $error("command load without an accepted transaction");

  // Each result strobe lasts one cycle and frees the block afterwards.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe longer than one cycle");

  // An accepted transaction keeps the block busy.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("block not busy after accepting a transaction");

  // No status code outside ok, error and blocked is ever reported.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == rrtm_pkg::STAT_OK || status_o == rrtm_pkg::STAT_ERROR ||
                status_o == rrtm_pkg::STAT_BLOCKED))
    else $error("undefined status code reported");
`endif

endmodule
